// ----- rtl/decision_hysteresis_filter_core_assert.svh -----
// Assertion macros shared by the decision hysteresis filter RTL.
// No dependencies; include after the module's signals are declared.
`ifndef DECISION_HYSTERESIS_FILTER_CORE_ASSERT_SVH
`define DECISION_HYSTERESIS_FILTER_CORE_ASSERT_SVH

// same-cycle implication, held off during reset
`define DHF_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dhf assertion failed");

// next-cycle implication, held off during reset
`define DHF_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dhf assertion failed");

`endif

// ----- rtl/dhf_pkg.sv -----
// Shared types and constants for the decision hysteresis filter.
// No dependencies; used by dhf_div and decision_hysteresis_filter_core.
`default_nettype none

package dhf_pkg;

  localparam int SLOTS_DEF        = 64;
  localparam int WINDOW_DEPTH_DEF = 10;

  localparam int STATE_W = 3;
  localparam int RUN_W   = 16;
  localparam int CFG_W   = 4;
  localparam int Q_W     = 17;           // confidence, Q1.16 up to 1.0
  localparam int SUM_W   = 18;           // sum of up to 16 weights
  localparam int NUM_W   = Q_W + SUM_W + 1;

  localparam logic [CFG_W-1:0] HYST_RESET = 4'd3;
  localparam logic [RUN_W-1:0] RUN_MAX    = 16'hFFFF;

  // round(0.7^i * 65536), newest entry first
  localparam logic [Q_W-1:0] WEIGHT_Q16 [16] = '{
    17'd65536, 17'd45875, 17'd32113, 17'd22479, 17'd15735, 17'd11015, 17'd7710, 17'd5397,
    17'd3778,  17'd2645,  17'd1851,  17'd1296,  17'd907,   17'd635,   17'd444,  17'd311
  };

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE,
    ST_SUM,
    ST_LAUNCH,
    ST_DIV,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/decision_hysteresis_filter_core.sv -----
// Per-slot decision debouncer. Each beat names a slot, a proposed state and a
// first-seen flag; the slot record (state, run, raw and accepted histories) lives in
// one SLOTS-deep memory that is read, updated and written back per beat. One result
// beat per input beat; a new item is accepted only once the last result has been emitted.
// For the n entries, n being the accepted-history fill (1..WINDOW_DEPTH), one
// weight per cycle is summed for the confidence, then a 17-step divider forms the ratio.
// After reset a clearing pass writes every slot with in_ready low; the config register
// can be written at any time the block is idle.
`default_nettype none

module decision_hysteresis_filter_core
  import dhf_pkg::*;
#(
  parameter int SLOTS        = SLOTS_DEF,
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CFG_W-1:0]   cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [5:0]         slot,
  input  wire logic [STATE_W-1:0] proposed_state,
  input  wire logic               first_seen,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [STATE_W-1:0]      accepted_state,
  output logic [RUN_W-1:0]        run_count,
  output logic [Q_W-1:0]          confidence,
  output logic                    state_changed
);

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int WIN_W  = STATE_W * WINDOW_DEPTH;
  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int IDX_W  = $clog2(WINDOW_DEPTH);
  localparam int CMP_W  = (FILL_W > CFG_W) ? FILL_W : CFG_W;
  localparam int WORD_W = STATE_W + RUN_W + 2 * (WIN_W + FILL_W);

  function automatic logic [SLOT_W-1:0] slot_mod(input logic [5:0] v);
    logic [SLOT_W-1:0] r;
    r = '0;
    for (int k = 0; k < 64; k++) begin
      if (v == 6'(k)) r = SLOT_W'(k % SLOTS);
    end
    return r;
  endfunction

  state_t state, state_next;

  logic [CFG_W-1:0]   hysteresis_count;
  logic [WORD_W-1:0]  mem [SLOTS];
  logic [WORD_W-1:0]  rd_word;
  logic [SLOT_W-1:0]  clr_addr;
  logic [SLOT_W-1:0]  cur_slot;
  logic [STATE_W-1:0] prop_q;
  logic               first_q;

  logic               in_fire;
  logic               mem_we;
  logic               clr_last;
  logic               sum_last;
  logic               div_start;
  logic               div_busy;
  logic               div_done;
  logic [Q_W-1:0]     div_quot;
  logic               emit;

  // decoded slot record
  logic [WORD_W-1:0]  w;
  logic [STATE_W-1:0] w_cur;
  logic [RUN_W-1:0]   w_run;
  logic [WIN_W-1:0]   w_raw;
  logic [FILL_W-1:0]  w_rfill;
  logic [WIN_W-1:0]   w_acw;
  logic [FILL_W-1:0]  w_afill;

  // updated record
  logic [WIN_W-1:0]   raw_new;
  logic [FILL_W-1:0]  rfill_new;
  logic               same;
  logic [STATE_W-1:0] acc_new;
  logic [RUN_W-1:0]   run_new;
  logic [WIN_W-1:0]   acw_new;
  logic [FILL_W-1:0]  afill_new;

  // working registers for the confidence sum
  logic [STATE_W-1:0] acc_q;
  logic [RUN_W-1:0]   run_q;
  logic               chg_q;
  logic [WIN_W-1:0]   acw_q;
  logic [FILL_W-1:0]  afill_q;
  logic [IDX_W-1:0]   idx;
  logic [SUM_W-1:0]   csum;
  logic [SUM_W-1:0]   tsum;
  logic [Q_W-1:0]     wt;
  logic [NUM_W-1:0]   div_num;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign clr_last  = clr_addr == SLOT_W'(SLOTS - 1);
  assign sum_last  = (FILL_W'(idx) + FILL_W'(1)) == afill_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      hysteresis_count <= HYST_RESET;
    end else if (cfg_valid && cfg_ready) begin
      hysteresis_count <= cfg_data;
    end
  end

  // ---------------- control ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + SLOT_W'(1);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clr_last) state_next = ST_IDLE;
      ST_IDLE:   if (in_valid) state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_SUM;
      ST_SUM:    if (sum_last) state_next = ST_LAUNCH;
      ST_LAUNCH: state_next = ST_DIV;
      ST_DIV:    if (div_done) state_next = ST_EMIT;
      ST_EMIT:   if (!out_valid || out_ready) state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    div_start = 1'b0;
    emit      = 1'b0;
    unique case (state)
      ST_CLEAR:  mem_we = 1'b1;
      ST_IDLE:   in_ready = 1'b1;
      ST_UPDATE: mem_we = 1'b1;
      ST_SUM:    ;
      ST_LAUNCH: div_start = 1'b1;
      ST_DIV:    ;
      ST_EMIT:   emit = !out_valid || out_ready;
      default:   ;
    endcase
  end

  // ---------------- slot memory ----------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[(state == ST_CLEAR) ? clr_addr : cur_slot] <=
        (state == ST_CLEAR) ? '0 : {acc_new, run_new, raw_new, rfill_new, acw_new, afill_new};
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_word  <= mem[slot_mod(slot)];
      cur_slot <= slot_mod(slot);
      prop_q   <= proposed_state;
      first_q  <= first_seen;
    end
  end

  // ---------------- record update ----------------
  assign w = first_q ? '0 : rd_word;
  assign {w_cur, w_run, w_raw, w_rfill, w_acw, w_afill} = w;

  always_comb begin
    raw_new   = {w_raw[WIN_W-STATE_W-1:0], prop_q};
    rfill_new = (w_rfill < FILL_W'(WINDOW_DEPTH)) ? w_rfill + FILL_W'(1) : w_rfill;
    same = 1'b1;
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      if (5'(i) < {1'b0, hysteresis_count} && raw_new[STATE_W*i +: STATE_W] != prop_q)
        same = 1'b0;
    end
    // change needs the newest hysteresis_count raw proposals to agree
    if (prop_q == w_cur || (CMP_W'(rfill_new) >= CMP_W'(hysteresis_count) && same))
      acc_new = prop_q;
    else
      acc_new = w_cur;
    if (acc_new == w_cur)
      run_new = (w_run == RUN_MAX) ? w_run : w_run + RUN_W'(1);
    else
      run_new = RUN_W'(1);
    acw_new   = {w_acw[WIN_W-STATE_W-1:0], acc_new};
    afill_new = (w_afill < FILL_W'(WINDOW_DEPTH)) ? w_afill + FILL_W'(1) : w_afill;
  end

  // ---------------- confidence sums ----------------
  assign wt = WEIGHT_Q16[4'(idx)];

  always_ff @(posedge clk) begin
    if (state == ST_UPDATE) begin
      acc_q   <= acc_new;
      run_q   <= run_new;
      chg_q   <= acc_new != w_cur;
      acw_q   <= acw_new;
      afill_q <= afill_new;
      idx     <= '0;
      csum    <= '0;
      tsum    <= '0;
    end else if (state == ST_SUM) begin
      idx  <= idx + IDX_W'(1);
      tsum <= tsum + SUM_W'(wt);
      if (acw_q[STATE_W*idx +: STATE_W] == acc_q) csum <= csum + SUM_W'(wt);
    end
  end

  // rounded ratio: (C * 65536 + S / 2) / S
  assign div_num = (NUM_W'(csum) << 16) + NUM_W'(tsum >> 1);

  dhf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (tsum),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      accepted_state <= acc_q;
      run_count      <= run_q;
      confidence     <= div_quot;
      state_changed  <= chg_q;
    end
  end

`include "decision_hysteresis_filter_core_assert.svh"

  `DHF_ASSERT_NXT(a_fire_to_update, clk, rst, in_fire, state == ST_UPDATE)
  `DHF_ASSERT_IMP(a_conf_bound, clk, rst, out_valid, confidence <= 17'd65536)
  `DHF_ASSERT_IMP(a_change_run, clk, rst, out_valid && state_changed, run_count == 16'd1)
  `DHF_ASSERT_IMP(a_div_only_in_div, clk, rst, div_busy, state == ST_DIV)

endmodule

`default_nettype wire

// ----- rtl/dhf_div.sv -----
// Restoring divider for the confidence ratio, one quotient bit per cycle.
// Depends on dhf_pkg and decision_hysteresis_filter_core_assert.svh.
`default_nettype none

module dhf_div
  import dhf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [SUM_W-1:0] den,
  output logic                  busy,
  output logic                  done,
  output logic [Q_W-1:0]        quot
);

  localparam int REM_W = NUM_W - Q_W;
  localparam int CNT_W = $clog2(Q_W);

  logic [REM_W-1:0] rem;
  logic [Q_W-1:0]   low;
  logic [CNT_W-1:0] cnt;
  logic [SUM_W-1:0] den_q;
  logic [REM_W-1:0] trial;
  logic             take;

  // quotient fits Q_W bits, so the top part of num is already below den
  assign trial = {rem[REM_W-2:0], low[Q_W-1]};
  assign take  = trial >= REM_W'(den_q);
  assign quot  = low;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(Q_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= num[NUM_W-1:Q_W];
      low   <= num[Q_W-1:0];
      den_q <= den;
    end else if (busy) begin
      rem <= take ? (trial - REM_W'(den_q)) : trial;
      low <= {low[Q_W-2:0], take};
    end
  end

`include "decision_hysteresis_filter_core_assert.svh"

  `DHF_ASSERT_IMP(a_start_idle, clk, rst, start, !busy)
  `DHF_ASSERT_NXT(a_done_after_last, clk, rst, busy && cnt == CNT_W'(Q_W - 1), done && !busy)
  `DHF_ASSERT_IMP(a_rem_below_den, clk, rst, busy, rem < REM_W'(den_q))

endmodule

`default_nettype wire
